// ===== sv/emabad_pkg.sv =====
package emabad_pkg;

    // Default widths of a temperature sample and of the learning counter.
    localparam int TEMP_WIDTH_DEF  = 16;
    localparam int COUNT_WIDTH_DEF = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_EMA_ALPHA         = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_LENGTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANOMALY_THRESHOLD = 2'd2;

    localparam int ALPHA_W = 17;
    localparam int LEN_W   = 16;
    localparam int THR_W   = 16;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE       = 17'h10000;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET     = 17'd6554;
    localparam logic [LEN_W-1:0]   LENGTH_RESET    = 16'd100;
    localparam logic [THR_W-1:0]   THRESHOLD_RESET = 16'd1280;

    // Rounding constant of the filter, one half in Q0.16.
    localparam logic [15:0] ROUND_HALF = 16'h8000;

    // Status codes.
    localparam int STAT_W = 2;
    localparam logic [STAT_W-1:0] ST_LEARNING = 2'd0;
    localparam logic [STAT_W-1:0] ST_NORMAL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_ANOMALY  = 2'd2;

endpackage

// ===== sv/ema_baseline_anomaly_detector.sv =====
// EMA baseline anomaly detector.
//
// Input channel: i_in_valid / o_in_stall with one signed Q8.8 sample on
// i_raw_temp. Output channel: o_out_valid / i_out_stall with the filtered
// sample on o_filtered_temp and its status on o_status (learning, normal,
// anomaly). Every input transfer yields exactly one output transfer.
// Configuration registers are written through i_cfg_we, i_cfg_index and
// i_cfg_data; indexes beyond the list are ignored. The user must write them
// only while the block is idle; the block itself does not enforce it.
//
// One shared adder does the product accumulation, the running sum and the
// trial subtraction. The filter product is formed by a shift-and-add over
// the 17 alpha bits. The sample that ends learning also runs a restoring
// division of the running sum by the sample count, one quotient bit per
// cycle. The next sample is taken once the result has moved into the output
// register, which holds it while the receiver stalls.
//
// Reset (synchronous, active low) loads the default configuration, clears
// the filter history, the learned baseline and the counters, and empties the
// output register; the first sample after reset passes through unfiltered.
module ema_baseline_anomaly_detector #(
    parameter int TEMP_WIDTH  = emabad_pkg::TEMP_WIDTH_DEF,
    parameter int COUNT_WIDTH = emabad_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [emabad_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [emabad_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [TEMP_WIDTH-1:0]        i_raw_temp,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [TEMP_WIDTH-1:0]        o_filtered_temp,
    output logic [emabad_pkg::STAT_W-1:0]       o_status
);
    import emabad_pkg::*;

    localparam int SUM_W   = TEMP_WIDTH + COUNT_WIDTH;
    localparam int P_W     = TEMP_WIDTH + 18;
    localparam int ALU_W0  = (P_W > SUM_W + 1) ? P_W : SUM_W + 1;
    localparam int ALU_W   = (ALU_W0 > COUNT_WIDTH + 2) ? ALU_W0 : COUNT_WIDTH + 2;
    localparam int CMP_W   = (TEMP_WIDTH + 1 > THR_W + 1) ? TEMP_WIDTH + 1 : THR_W + 1;
    localparam int CNT_C_W = (COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W;
    localparam int STEPS_MAX = (SUM_W > ALPHA_W) ? SUM_W : ALPHA_W;
    localparam int STEP_W  = $clog2(STEPS_MAX);

    localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(ALPHA_W - 1);
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(SUM_W - 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_FILT  = 3'd2;
    localparam logic [2:0] S_UPD   = 3'd3;
    localparam logic [2:0] S_DINIT = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_DFIN  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]                    r_state;
    logic [ALPHA_W-1:0]            r_alpha;
    logic [LEN_W-1:0]              r_len;
    logic [THR_W-1:0]              r_thr;

    logic signed [TEMP_WIDTH-1:0]  r_last;
    logic signed [TEMP_WIDTH-1:0]  r_filt;
    logic signed [TEMP_WIDTH-1:0]  r_base;
    logic [COUNT_WIDTH-1:0]        r_cnt;
    logic                          r_done;
    logic signed [SUM_W-1:0]       r_sum;

    logic signed [P_W-1:0]         r_prod;
    logic signed [P_W-1:0]         r_mcand;
    logic [ALPHA_W-1:0]            r_mplier;
    logic [STEP_W-1:0]             r_step;

    logic [SUM_W-1:0]              r_quo;
    logic [COUNT_WIDTH-1:0]        r_rem;
    logic                          r_neg;
    logic [STAT_W-1:0]             r_stat;

    logic                          r_out_valid;
    logic signed [TEMP_WIDTH-1:0]  r_out_filt;
    logic [STAT_W-1:0]             r_out_stat;

    logic [ALU_W-1:0]              alu_a;
    logic [ALU_W-1:0]              alu_b;
    logic                          alu_sub;
    logic [ALU_W-1:0]              alu_y;

    logic                          in_xfer;
    logic                          out_xfer;
    logic                          load_out;
    logic [ALPHA_W-1:0]            alpha_eff;
    logic signed [TEMP_WIDTH:0]    in_diff;
    logic [COUNT_WIDTH-1:0]        n_cnt;
    logic                          learn_end;
    logic [COUNT_WIDTH:0]          div_shift;
    logic [SUM_W-1:0]              sum_mag;
    logic [TEMP_WIDTH-1:0]         quo_low;
    logic signed [TEMP_WIDTH:0]    dev;
    logic [TEMP_WIDTH:0]           dev_mag;
    logic                          is_anomaly;

    assign o_in_stall      = (r_state != S_IDLE);
    assign in_xfer         = i_in_valid && !o_in_stall;
    assign out_xfer        = r_out_valid && !i_out_stall;
    assign load_out        = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);
    assign o_out_valid     = r_out_valid;
    assign o_filtered_temp = r_out_filt;
    assign o_status        = r_out_stat;

    assign alpha_eff = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;
    assign in_diff   = (TEMP_WIDTH + 1)'(i_raw_temp) - (TEMP_WIDTH + 1)'(r_last);

    assign n_cnt     = (r_cnt == '1) ? r_cnt : r_cnt + COUNT_WIDTH'(1);
    assign learn_end = (CNT_C_W'(n_cnt) >= CNT_C_W'(r_len)) || (n_cnt == '1);

    assign div_shift = {r_rem, r_quo[SUM_W-1]};
    assign sum_mag   = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign quo_low   = r_quo[TEMP_WIDTH-1:0];

    assign dev        = (TEMP_WIDTH + 1)'(r_filt) - (TEMP_WIDTH + 1)'(r_base);
    assign dev_mag    = dev[TEMP_WIDTH] ? (TEMP_WIDTH + 1)'(-dev) : (TEMP_WIDTH + 1)'(dev);
    assign is_anomaly = CMP_W'(dev_mag) > CMP_W'(r_thr);

    // The shared adder: product accumulation, running sum and trial subtraction.
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (r_state)
            S_MUL: begin
                alu_a = ALU_W'(r_prod);
                alu_b = ALU_W'(r_mcand);
            end
            S_UPD: begin
                alu_a = ALU_W'(r_sum);
                alu_b = ALU_W'(r_filt);
            end
            S_DIV: begin
                alu_a   = ALU_W'(div_shift);
                alu_b   = ALU_W'(r_cnt);
                alu_sub = 1'b1;
            end
            default: begin
                alu_a = '0;
            end
        endcase
        alu_y = alu_sub ? alu_a - alu_b : alu_a + alu_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RESET;
            r_len   <= LENGTH_RESET;
            r_thr   <= THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_EMA_ALPHA:         r_alpha <= i_cfg_data[ALPHA_W-1:0];
                CFG_LEARNING_LENGTH:   r_len   <= i_cfg_data[LEN_W-1:0];
                CFG_ANOMALY_THRESHOLD: r_thr   <= i_cfg_data[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= '0;
            r_cnt       <= '0;
            r_done      <= 1'b0;
            r_sum       <= '0;
            r_base      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A new result may replace the one leaving in the same cycle.
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_prod   <= P_W'(signed'({r_last, ROUND_HALF}));
                        r_mcand  <= P_W'(in_diff);
                        r_mplier <= alpha_eff;
                        r_step   <= '0;
                        if (r_cnt == '0) begin
                            r_filt  <= i_raw_temp;
                            r_state <= S_UPD;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    if (r_mplier[0]) begin
                        r_prod <= P_W'(alu_y);
                    end
                    r_mcand  <= r_mcand <<< 1;
                    r_mplier <= r_mplier >> 1;
                    r_step   <= r_step + STEP_W'(1);
                    if (r_step == MUL_LAST) begin
                        r_state <= S_FILT;
                    end
                end
                S_FILT: begin
                    // Floor shift by 16 after the half-unit rounding offset.
                    r_filt  <= r_prod[TEMP_WIDTH+15:16];
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_last <= r_filt;
                    if (!r_done) begin
                        r_cnt  <= n_cnt;
                        r_sum  <= SUM_W'(alu_y);
                        r_stat <= ST_LEARNING;
                        r_state <= learn_end ? S_DINIT : S_OUT;
                    end else begin
                        r_stat  <= is_anomaly ? ST_ANOMALY : ST_NORMAL;
                        r_state <= S_OUT;
                    end
                end
                S_DINIT: begin
                    r_quo   <= sum_mag;
                    r_neg   <= r_sum[SUM_W-1];
                    r_rem   <= '0;
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // A non-negative trial difference means the divisor fits.
                    if (!alu_y[ALU_W-1]) begin
                        r_rem <= alu_y[COUNT_WIDTH-1:0];
                    end else begin
                        r_rem <= div_shift[COUNT_WIDTH-1:0];
                    end
                    r_quo  <= {r_quo[SUM_W-2:0], !alu_y[ALU_W-1]};
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == DIV_LAST) begin
                        r_state <= S_DFIN;
                    end
                end
                S_DFIN: begin
                    r_base  <= r_neg ? signed'(-quo_low) : signed'(quo_low);
                    r_done  <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (load_out) begin
                        r_out_filt  <= r_filt;
                        r_out_stat  <= r_stat;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== test/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import emabad_pkg::*;

    localparam int TW          = TEMP_WIDTH_DEF;
    localparam int CW          = COUNT_WIDTH_DEF;
    localparam int TEMP_MAX    = 2 ** (TW - 1) - 1;
    localparam int TEMP_MIN    = -(2 ** (TW - 1));
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 60;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 60;

    // Index with no register behind it; the block must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;
    localparam logic [CW-1:0]        COUNT_FULL = '1;

    typedef struct {
        logic signed [TW-1:0] filt;
        logic [STAT_W-1:0]    stat;
    } t_ema_out;

    typedef enum {ROW_CFG, ROW_TEMP, ROW_NEAR_BASE} t_row_kind;

    typedef struct {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        int                   val;
        bit                   typed;
        int                   t_filt;
        logic [STAT_W-1:0]    t_stat;
    } t_dir_row;

    // Samples near the baseline carry an offset from the learned mean in val.
    t_dir_row dir_tab [29] = '{
        '{ROW_TEMP,      CFG_EMA_ALPHA,         -32768, 1'b1, -32768, ST_LEARNING},
        '{ROW_CFG,       CFG_EMA_ALPHA,         131071, 1'b0,      0, ST_LEARNING},
        '{ROW_TEMP,      CFG_EMA_ALPHA,          32767, 1'b1,  32767, ST_LEARNING},
        '{ROW_CFG,       CFG_EMA_ALPHA,              0, 1'b0,      0, ST_LEARNING},
        '{ROW_TEMP,      CFG_EMA_ALPHA,              0, 1'b1,  32767, ST_LEARNING},
        '{ROW_CFG,       CFG_EMA_ALPHA,          65536, 1'b0,      0, ST_LEARNING},
        '{ROW_TEMP,      CFG_EMA_ALPHA,         -32768, 1'b1, -32768, ST_LEARNING},
        '{ROW_CFG,       CFG_EMA_ALPHA,              1, 1'b0,      0, ST_LEARNING},
        '{ROW_TEMP,      CFG_EMA_ALPHA,          32767, 1'b0,      0, ST_LEARNING},
        '{ROW_CFG,       CFG_EMA_ALPHA,          32768, 1'b0,      0, ST_LEARNING},
        '{ROW_TEMP,      CFG_EMA_ALPHA,         -12345, 1'b0,      0, ST_LEARNING},
        '{ROW_TEMP,      CFG_EMA_ALPHA,         -20000, 1'b0,      0, ST_LEARNING},
        '{ROW_CFG,       CFG_LEARNING_LENGTH,    65535, 1'b0,      0, ST_LEARNING},
        '{ROW_TEMP,      CFG_EMA_ALPHA,             -3, 1'b0,      0, ST_LEARNING},
        '{ROW_CFG,       CFG_LEARNING_LENGTH,        0, 1'b0,      0, ST_LEARNING},
        '{ROW_TEMP,      CFG_EMA_ALPHA,             -7, 1'b0,      0, ST_LEARNING},
        '{ROW_CFG,       CFG_ANOMALY_THRESHOLD,      0, 1'b0,      0, ST_LEARNING},
        '{ROW_CFG,       CFG_EMA_ALPHA,          65536, 1'b0,      0, ST_LEARNING},
        '{ROW_NEAR_BASE, CFG_EMA_ALPHA,              0, 1'b0,      0, ST_LEARNING},
        '{ROW_NEAR_BASE, CFG_EMA_ALPHA,              1, 1'b0,      0, ST_LEARNING},
        '{ROW_NEAR_BASE, CFG_EMA_ALPHA,             -1, 1'b0,      0, ST_LEARNING},
        '{ROW_CFG,       CFG_ANOMALY_THRESHOLD,  65535, 1'b0,      0, ST_LEARNING},
        '{ROW_TEMP,      CFG_EMA_ALPHA,          32767, 1'b0,      0, ST_LEARNING},
        '{ROW_TEMP,      CFG_EMA_ALPHA,         -32768, 1'b0,      0, ST_LEARNING},
        '{ROW_CFG,       CFG_ANOMALY_THRESHOLD,      5, 1'b0,      0, ST_LEARNING},
        '{ROW_NEAR_BASE, CFG_EMA_ALPHA,              5, 1'b0,      0, ST_LEARNING},
        '{ROW_NEAR_BASE, CFG_EMA_ALPHA,             -6, 1'b0,      0, ST_LEARNING},
        '{ROW_CFG,       CFG_NO_REG,            131071, 1'b0,      0, ST_LEARNING},
        '{ROW_NEAR_BASE, CFG_EMA_ALPHA,              5, 1'b0,      0, ST_LEARNING}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic signed [TW-1:0]  i_raw_temp;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic signed [TW-1:0]  o_filtered_temp;
    logic [STAT_W-1:0]     o_status;

    // Shadow of the configuration and of the filter and learning state.
    logic [ALPHA_W-1:0]        cur_alpha;
    logic [LEN_W-1:0]          cur_len;
    logic [THR_W-1:0]          cur_thr;
    logic signed [TW-1:0]      prev_filt;
    logic [CW-1:0]             seen_cnt;
    bit                        learned;
    logic signed [TW+CW-1:0]   learn_sum;
    logic signed [TW-1:0]      base_temp;

    t_ema_out pending_q [$];
    int       err_cnt = 0;
    bit       tx_gaps = 1'b0;
    bit       rx_gaps = 1'b0;
    bit       hold_req = 1'b0;

    ema_baseline_anomaly_detector #(
        .TEMP_WIDTH  (TW),
        .COUNT_WIDTH (CW)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_raw_temp      (i_raw_temp),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_filtered_temp (o_filtered_temp),
        .o_status        (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic signed [TW-1:0] clip_temp(input int v);
        if (v > TEMP_MAX) begin
            return TW'(TEMP_MAX);
        end
        if (v < TEMP_MIN) begin
            return TW'(TEMP_MIN);
        end
        return TW'(v);
    endfunction

    // Filters one sample, advances the learning state and grades the result.
    function automatic t_ema_out ema_predict(input logic signed [TW-1:0] raw);
        t_ema_out res;
        longint   a;
        longint   acc;
        longint   dev;
        if (seen_cnt == 0) begin
            res.filt = raw;
        end else begin
            a = (cur_alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(cur_alpha);
            acc = a * longint'(raw) + (longint'(ALPHA_ONE) - a) * longint'(prev_filt)
                + longint'(ROUND_HALF);
            res.filt = TW'(acc >>> 16);
        end
        prev_filt = res.filt;
        if (!learned) begin
            if (seen_cnt != COUNT_FULL) begin
                seen_cnt = seen_cnt + 1'b1;
            end
            learn_sum = learn_sum + res.filt;
            if (seen_cnt >= cur_len || seen_cnt == COUNT_FULL) begin
                // Division truncates toward zero, as longint division does.
                base_temp = TW'(longint'(learn_sum) / longint'(seen_cnt));
                learned = 1'b1;
            end
            res.stat = ST_LEARNING;
        end else begin
            dev = longint'(res.filt) - longint'(base_temp);
            if (dev < 0) begin
                dev = -dev;
            end
            res.stat = (dev > longint'(cur_thr)) ? ST_ANOMALY : ST_NORMAL;
        end
        return res;
    endfunction

    // Holds the input back until every outstanding result has been received.
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending_q.size() != 0);
    endtask

    // The write enable stays high until the next sample is sent.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_EMA_ALPHA:         cur_alpha = data;
            CFG_LEARNING_LENGTH:   cur_len   = data[LEN_W-1:0];
            CFG_ANOMALY_THRESHOLD: cur_thr   = data[THR_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic send_temp(input logic signed [TW-1:0] raw, input bit typed,
                             input t_ema_out typed_res);
        t_ema_out pred;
        i_cfg_we   <= 1'b0;
        i_in_valid <= 1'b1;
        i_raw_temp <= raw;
        do @(posedge i_clk); while (o_in_stall);
        pred = ema_predict(raw);
        if (typed) begin
            pending_q.push_back(typed_res);
        end else begin
            pending_q.push_back(pred);
        end
        @(negedge i_clk);
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
    endtask

    // Output side: random stall bursts, plus one long hold-off on request.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_out_stall <= 1'b0;
                hold_req = 1'b0;
            end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_ema_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, got %0d status %0d",
                         $time, o_filtered_temp, o_status);
                err_cnt++;
            end else begin
                want = pending_q.pop_front();
                if (o_filtered_temp !== want.filt) begin
                    $display("%0t: filtered_temp mismatch, expected %0d, got %0d",
                             $time, want.filt, o_filtered_temp);
                    err_cnt++;
                end
                if (o_status !== want.stat) begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.stat, o_status);
                    err_cnt++;
                end
            end
        end
    end

    // Ends the run when no transfer happens on either channel for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        t_ema_out              typed_res;
        logic [CFG_DATA_W-1:0] reg_val;
        logic signed [TW-1:0]  raw;
        int                    span;

        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_EMA_ALPHA;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_raw_temp  = '0;
        cur_alpha   = ALPHA_RESET;
        cur_len     = LENGTH_RESET;
        cur_thr     = THRESHOLD_RESET;
        prev_filt   = '0;
        seen_cnt    = '0;
        learned     = 1'b0;
        learn_sum   = '0;
        base_temp   = '0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        foreach (dir_tab[k]) begin
            typed_res.filt = TW'(dir_tab[k].t_filt);
            typed_res.stat = dir_tab[k].t_stat;
            case (dir_tab[k].kind)
                ROW_CFG:
                    cfg_write(dir_tab[k].reg_idx, CFG_DATA_W'(dir_tab[k].val));
                ROW_TEMP:
                    send_temp(TW'(dir_tab[k].val), dir_tab[k].typed, typed_res);
                default:
                    send_temp(clip_temp(int'(base_temp) + dir_tab[k].val), 1'b0, typed_res);
            endcase
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            tx_gaps = (ph < PHASES - 1) && ($urandom_range(0, 3) != 0);
            rx_gaps = (ph < PHASES - 1) && ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 5))
                0:       reg_val = ALPHA_ONE;
                1:       reg_val = CFG_DATA_W'($urandom_range(65537, 131071));
                2:       reg_val = '0;
                default: reg_val = CFG_DATA_W'($urandom_range(1, 65535));
            endcase
            cfg_write(CFG_EMA_ALPHA, reg_val);
            cfg_write(CFG_LEARNING_LENGTH, CFG_DATA_W'($urandom_range(0, 65535)));
            case ($urandom_range(0, 3))
                0:       reg_val = '0;
                1:       reg_val = 17'd65535;
                default: reg_val = CFG_DATA_W'($urandom_range(0, 3000));
            endcase
            cfg_write(CFG_ANOMALY_THRESHOLD, reg_val);
            // Receiver holds off while samples keep coming, so the block backs up.
            if (ph == 3) begin
                hold_req = 1'b1;
            end
            span = int'(cur_thr) + 40;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 5 && n == PHASE_ITEMS / 2) begin
                    settle();
                end
                if ($urandom_range(0, 3) == 0) begin
                    raw = TW'($urandom);
                end else begin
                    raw = clip_temp(int'(base_temp) + int'($urandom_range(0, 2 * span)) - span);
                end
                send_temp(raw, 1'b0, typed_res);
            end
        end

        settle();
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/emabad_pkg.sv
sv/ema_baseline_anomaly_detector.sv
test/tb.sv
